// File: design/duffing_trapezoid_newton_step_unit_assert.svh
// Assertion macros shared by the Duffing step unit.
`ifndef DUFFING_TRAPEZOID_NEWTON_STEP_UNIT_ASSERT_SVH
`define DUFFING_TRAPEZOID_NEWTON_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DTN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtn assertion failed");

// Next-cycle implication, checked outside reset.
`define DTN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtn assertion failed");

`endif

// File: design/dtn_pkg.sv
package dtn_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int NEWTON_ITERS_DEF = 2;

    localparam int H_W   = 17;
    localparam int XI_W  = 20;
    localparam int CFG_W = 20;
    localparam int PC_W  = 7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP = 2'd0;
    localparam logic [1:0] CFG_DAMP = 2'd1;
    localparam logic [1:0] CFG_LIN  = 2'd2;

    localparam logic [H_W-1:0]  H_RESET  = 17'd655;
    localparam logic [XI_W-1:0] XI_RESET = 20'd3277;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_DIVW,
        S_PUSH
    } t_state;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_SAT,
        OP_LIN,
        OP_DIV,
        OP_BRZ,
        OP_JMP,
        OP_LOOP,
        OP_PEAK,
        OP_END
    } t_op;

    // Operand and destination codes: scratch entries, then special sources.
    localparam logic [4:0] T0  = 5'd0;
    localparam logic [4:0] T1  = 5'd1;
    localparam logic [4:0] T2  = 5'd2;
    localparam logic [4:0] T3  = 5'd3;
    localparam logic [4:0] T4  = 5'd4;
    localparam logic [4:0] T5  = 5'd5;
    localparam logic [4:0] T6  = 5'd6;
    localparam logic [4:0] T7  = 5'd7;
    localparam logic [4:0] T8  = 5'd8;
    localparam logic [4:0] T9  = 5'd9;
    localparam logic [4:0] T10 = 5'd10;
    localparam logic [4:0] T11 = 5'd11;
    localparam logic [4:0] T12 = 5'd12;
    localparam logic [4:0] T13 = 5'd13;
    localparam logic [4:0] T14 = 5'd14;
    localparam logic [4:0] T15 = 5'd15;
    localparam logic [4:0] SRC_ZERO = 5'd16;
    localparam logic [4:0] SRC_ONE  = 5'd17;
    localparam logic [4:0] SRC_H    = 5'd18;
    localparam logic [4:0] SRC_HH   = 5'd19;
    localparam logic [4:0] SRC_XI   = 5'd20;
    localparam logic [4:0] SRC_X2   = 5'd21;
    localparam logic [4:0] SRC_DISP = 5'd22;
    localparam logic [4:0] SRC_VEL  = 5'd23;
    localparam logic [4:0] SRC_ACC  = 5'd24;
    localparam logic [4:0] SRC_PF   = 5'd25;
    localparam logic [4:0] SRC_DIN  = 5'd26;
    localparam logic [4:0] SRC_VIN  = 5'd27;
    localparam logic [4:0] SRC_FIN  = 5'd28;

    localparam logic [PC_W-1:0] PC_STEP  = 7'd0;
    localparam logic [PC_W-1:0] PC_LOOP  = 7'd28;
    localparam logic [PC_W-1:0] PC_LEND  = 7'd70;
    localparam logic [PC_W-1:0] PC_ACCEL = 7'd72;
    localparam logic [PC_W-1:0] PC_LOAD  = 7'd85;

    typedef struct packed {
        t_op             op;
        logic [4:0]      dst;
        logic [4:0]      sa;
        logic [4:0]      sb;
        logic [PC_W-1:0] tgt;
    } t_uop;

    typedef struct packed {
        logic [H_W-1:0]  h;
        logic [XI_W-1:0] xi;
        logic            lin;
    } t_cfg;

    // Sequencer to datapath controls.
    typedef struct packed {
        logic start;
        logic fetch;
        logic exec;
        logic div_start;
        logic div_wb;
        logic zero_hit;
        logic peak_en;
        logic finish;
        logic load;
        t_uop uop;
    } t_dp_ctl;

    typedef struct packed {
        logic a_zero;
        logic div_done;
    } t_dp_stat;

    function automatic t_uop mk(t_op op, logic [4:0] dst, logic [4:0] sa, logic [4:0] sb,
                                logic [PC_W-1:0] tgt);
        t_uop u;
        u.op  = op;
        u.dst = dst;
        u.sa  = sa;
        u.sb  = sb;
        u.tgt = tgt;
        return u;
    endfunction

    // Micro-program: step sequence, Newton loop, acceleration and write-back, load entry.
    function automatic t_uop uop_at(logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(OP_END, T0, T0, T0, PC_STEP);
        case (pc)
            // Predictor.
            7'd0:  u = mk(OP_MUL, T0, SRC_ACC, SRC_HH, PC_STEP);
            7'd1:  u = mk(OP_ADD, T0, SRC_VEL, T0, PC_STEP);
            7'd2:  u = mk(OP_SAT, T0, T0, T0, PC_STEP);
            7'd3:  u = mk(OP_MUL, T0, T0, SRC_H, PC_STEP);
            7'd4:  u = mk(OP_ADD, T0, SRC_DISP, T0, PC_STEP);
            7'd5:  u = mk(OP_SAT, T1, T0, T0, PC_STEP);
            7'd6:  u = mk(OP_MUL, T0, SRC_ACC, SRC_H, PC_STEP);
            7'd7:  u = mk(OP_ADD, T0, SRC_VEL, T0, PC_STEP);
            7'd8:  u = mk(OP_SAT, T2, T0, T0, PC_STEP);
            // Right-hand side.
            7'd9:  u = mk(OP_LIN, T0, SRC_DISP, SRC_ZERO, PC_STEP);
            7'd10: u = mk(OP_MUL, T0, T0, T0, PC_STEP);
            7'd11: u = mk(OP_ADD, T0, SRC_ONE, T0, PC_STEP);
            7'd12: u = mk(OP_SAT, T3, T0, T0, PC_STEP);
            7'd13: u = mk(OP_MUL, T0, SRC_VEL, SRC_HH, PC_STEP);
            7'd14: u = mk(OP_ADD, T0, SRC_DISP, T0, PC_STEP);
            7'd15: u = mk(OP_SAT, T4, T0, T0, PC_STEP);
            7'd16: u = mk(OP_ADD, T0, SRC_PF, SRC_FIN, PC_STEP);
            7'd17: u = mk(OP_MUL, T5, T3, SRC_DISP, PC_STEP);
            7'd18: u = mk(OP_SUB, T0, T0, T5, PC_STEP);
            7'd19: u = mk(OP_MUL, T5, SRC_X2, SRC_VEL, PC_STEP);
            7'd20: u = mk(OP_SUB, T0, T0, T5, PC_STEP);
            7'd21: u = mk(OP_SAT, T0, T0, T0, PC_STEP);
            7'd22: u = mk(OP_MUL, T0, T0, SRC_HH, PC_STEP);
            7'd23: u = mk(OP_ADD, T0, SRC_VEL, T0, PC_STEP);
            7'd24: u = mk(OP_SAT, T5, T0, T0, PC_STEP);
            7'd25: u = mk(OP_MUL, T0, SRC_XI, SRC_H, PC_STEP);
            7'd26: u = mk(OP_ADD, T0, SRC_ONE, T0, PC_STEP);
            7'd27: u = mk(OP_SAT, T6, T0, T0, PC_STEP);
            // Newton iteration.
            7'd28: u = mk(OP_LIN, T0, T1, SRC_ZERO, PC_STEP);
            7'd29: u = mk(OP_MUL, T7, T0, T0, PC_STEP);
            7'd30: u = mk(OP_ADD, T0, SRC_ONE, T7, PC_STEP);
            7'd31: u = mk(OP_SAT, T8, T0, T0, PC_STEP);
            7'd32: u = mk(OP_ADD, T0, T7, T7, PC_STEP);
            7'd33: u = mk(OP_ADD, T0, T0, T7, PC_STEP);
            7'd34: u = mk(OP_ADD, T0, SRC_ONE, T0, PC_STEP);
            7'd35: u = mk(OP_SAT, T9, T0, T0, PC_STEP);
            7'd36: u = mk(OP_MUL, T0, T8, SRC_HH, PC_STEP);
            7'd37: u = mk(OP_SAT, T10, T0, T0, PC_STEP);
            7'd38: u = mk(OP_MUL, T0, T9, SRC_HH, PC_STEP);
            7'd39: u = mk(OP_SAT, T11, T0, T0, PC_STEP);
            7'd40: u = mk(OP_MUL, T0, SRC_HH, T2, PC_STEP);
            7'd41: u = mk(OP_SUB, T0, T1, T0, PC_STEP);
            7'd42: u = mk(OP_SUB, T0, T0, T4, PC_STEP);
            7'd43: u = mk(OP_SAT, T12, T0, T0, PC_STEP);
            7'd44: u = mk(OP_MUL, T0, T10, T1, PC_STEP);
            7'd45: u = mk(OP_MUL, T13, T6, T2, PC_STEP);
            7'd46: u = mk(OP_ADD, T0, T0, T13, PC_STEP);
            7'd47: u = mk(OP_SUB, T0, T0, T5, PC_STEP);
            7'd48: u = mk(OP_SAT, T13, T0, T0, PC_STEP);
            7'd49: u = mk(OP_SUB, T12, SRC_ZERO, T12, PC_STEP);
            7'd50: u = mk(OP_SUB, T13, SRC_ZERO, T13, PC_STEP);
            7'd51: u = mk(OP_MUL, T0, SRC_HH, T11, PC_STEP);
            7'd52: u = mk(OP_ADD, T0, T6, T0, PC_STEP);
            7'd53: u = mk(OP_SAT, T14, T0, T0, PC_STEP);
            7'd54: u = mk(OP_BRZ, T0, T14, T14, PC_LEND);
            7'd55: u = mk(OP_SAT, T15, T12, T12, PC_STEP);
            7'd56: u = mk(OP_MUL, T0, T15, T6, PC_STEP);
            7'd57: u = mk(OP_SAT, T8, T13, T13, PC_STEP);
            7'd58: u = mk(OP_MUL, T9, SRC_HH, T8, PC_STEP);
            7'd59: u = mk(OP_ADD, T0, T0, T9, PC_STEP);
            7'd60: u = mk(OP_SAT, T0, T0, T0, PC_STEP);
            7'd61: u = mk(OP_DIV, T0, T0, T14, PC_STEP);
            7'd62: u = mk(OP_ADD, T0, T1, T0, PC_STEP);
            7'd63: u = mk(OP_SAT, T1, T0, T0, PC_STEP);
            7'd64: u = mk(OP_MUL, T0, T11, T15, PC_STEP);
            7'd65: u = mk(OP_SUB, T0, T13, T0, PC_STEP);
            7'd66: u = mk(OP_SAT, T0, T0, T0, PC_STEP);
            7'd67: u = mk(OP_DIV, T0, T0, T14, PC_STEP);
            7'd68: u = mk(OP_ADD, T0, T2, T0, PC_STEP);
            7'd69: u = mk(OP_SAT, T2, T0, T0, PC_STEP);
            7'd70: u = mk(OP_LOOP, T0, T0, T0, PC_LOOP);
            7'd71: u = mk(OP_PEAK, T0, SRC_VEL, T2, PC_STEP);
            // Acceleration and state write-back, shared with load.
            // The linear spring picks one before the clip, so it never clips.
            7'd72: u = mk(OP_MUL, T0, T1, T1, PC_STEP);
            7'd73: u = mk(OP_ADD, T0, SRC_ONE, T0, PC_STEP);
            7'd74: u = mk(OP_LIN, T0, T0, SRC_ONE, PC_STEP);
            7'd75: u = mk(OP_SAT, T0, T0, T0, PC_STEP);
            7'd76: u = mk(OP_MUL, T3, SRC_X2, T2, PC_STEP);
            7'd77: u = mk(OP_SUB, T3, SRC_FIN, T3, PC_STEP);
            7'd78: u = mk(OP_MUL, T0, T1, T0, PC_STEP);
            7'd79: u = mk(OP_SUB, T0, T3, T0, PC_STEP);
            7'd80: u = mk(OP_SAT, SRC_ACC, T0, T0, PC_STEP);
            7'd81: u = mk(OP_SAT, SRC_DISP, T1, T1, PC_STEP);
            7'd82: u = mk(OP_SAT, SRC_VEL, T2, T2, PC_STEP);
            7'd83: u = mk(OP_SAT, SRC_PF, SRC_FIN, SRC_FIN, PC_STEP);
            7'd84: u = mk(OP_END, T0, T0, T0, PC_STEP);
            // Load entry.
            7'd85: u = mk(OP_SAT, T1, SRC_DIN, SRC_DIN, PC_STEP);
            7'd86: u = mk(OP_SAT, T2, SRC_VIN, SRC_VIN, PC_STEP);
            7'd87: u = mk(OP_JMP, T0, T0, T0, PC_ACCEL);
            default: u = mk(OP_END, T0, T0, T0, PC_STEP);
        endcase
        return u;
    endfunction

endpackage

// File: design/dtn_in_if.sv
interface dtn_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] disp_in;
    logic signed [31:0] vel_in;
    logic signed [31:0] force_in;

    modport source (output valid, output func, output disp_in, output vel_in,
                    output force_in, input ready);
    modport sink (input valid, input func, input disp_in, input vel_in,
                  input force_in, output ready);
endinterface

// File: design/dtn_out_if.sv
interface dtn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] disp_out;
    logic signed [31:0] vel_out;
    logic signed [31:0] accel_out;
    logic               peak_seen;
    logic               saturated;

    modport source (output valid, output disp_out, output vel_out, output accel_out,
                    output peak_seen, output saturated, input ready);
    modport sink (input valid, input disp_out, input vel_out, input accel_out,
                  input peak_seen, input saturated, output ready);
endinterface

// File: design/dtn_divider.sv
module dtn_divider #(
    parameter int FRAC_BITS = dtn_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [31:0]       i_num,
    input  logic signed [31:0]       i_den,
    output logic                     o_done,
    output logic signed [32+FRAC_BITS:0] o_quot
);

    localparam int QW = 32 + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [31:0]   r_rem;
    logic [QW-1:0] r_quo;
    logic [31:0]   r_dv;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_done;

    logic [31:0] abs_n;
    logic [31:0] abs_d;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // Magnitudes; the most negative value maps to its unsigned magnitude.
    assign abs_n = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign abs_d = i_den[31] ? (~i_den + 32'd1) : i_den;

    // One restoring step per cycle.
    assign trial = {r_rem, r_quo[QW-1]};
    assign diff  = trial - {1'b0, r_dv};
    assign ge    = (trial >= {1'b0, r_dv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= CW'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {abs_n, {FRAC_BITS{1'b0}}};
            r_dv  <= abs_d;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[31:0] : trial[31:0];
            r_quo <= {r_quo[QW-2:0], ge};
        end
    end

    // Quotient truncated toward zero.
    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

// File: design/dtn_datapath.sv
module dtn_datapath #(
    parameter int FRAC_BITS = dtn_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtn_pkg::t_dp_ctl   i_ctl,
    input  dtn_pkg::t_cfg      i_cfg,
    input  logic signed [31:0] i_disp,
    input  logic signed [31:0] i_vel,
    input  logic signed [31:0] i_force,
    output dtn_pkg::t_dp_stat  o_stat,
    output logic signed [31:0] o_disp,
    output logic signed [31:0] o_vel,
    output logic signed [31:0] o_accel,
    output logic               o_peak,
    output logic               o_clip
);

    localparam int RW = (72 - FRAC_BITS > 34 + FRAC_BITS) ? 72 - FRAC_BITS : 34 + FRAC_BITS;
    localparam int QW = 32 + FRAC_BITS;

    localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;
    localparam logic signed [RW-1:0] MAX_R = {{(RW-32){1'b0}}, 32'h7fff_ffff};
    localparam logic signed [RW-1:0] MIN_R = {{(RW-32){1'b1}}, 32'h8000_0000};
    localparam logic signed [65:0]   RND   = 66'(1) << (FRAC_BITS - 1);

    logic signed [RW-1:0] r_mem [16];
    logic signed [RW-1:0] r_opa;
    logic signed [RW-1:0] r_opb;
    logic signed [31:0]   r_disp;
    logic signed [31:0]   r_vel;
    logic signed [31:0]   r_accel;
    logic signed [31:0]   r_pf;
    logic signed [31:0]   r_din;
    logic signed [31:0]   r_vin;
    logic signed [31:0]   r_fin;
    logic                 r_clip;
    logic                 r_peak;
    logic                 r_first;

    logic signed [RW-1:0] spec_a;
    logic signed [RW-1:0] spec_b;
    logic signed [65:0]   prod;
    logic signed [65:0]   prod_sh;
    logic signed [RW-1:0] mul_res;
    logic signed [RW-1:0] sat_in;
    logic signed [RW-1:0] sat_out;
    logic                 sat_over;
    logic                 sat_under;
    logic                 sat_sel;
    logic signed [RW-1:0] wb_val;
    logic                 we;
    logic                 div_done;
    logic signed [QW:0]   div_q;

    // Special operand select.
    function automatic logic signed [RW-1:0] spec(
        input logic [4:0]         sel,
        input dtn_pkg::t_cfg      cfg,
        input logic signed [31:0] disp,
        input logic signed [31:0] vel,
        input logic signed [31:0] acc,
        input logic signed [31:0] pf,
        input logic signed [31:0] din,
        input logic signed [31:0] vin,
        input logic signed [31:0] fin
    );
        logic signed [RW-1:0] v;
        case (sel)
            dtn_pkg::SRC_ONE:  v = ONE_R;
            dtn_pkg::SRC_H:    v = RW'(cfg.h);
            dtn_pkg::SRC_HH:   v = RW'(cfg.h[dtn_pkg::H_W-1:1]);
            dtn_pkg::SRC_XI:   v = RW'(cfg.xi);
            dtn_pkg::SRC_X2:   v = RW'({cfg.xi, 1'b0});
            dtn_pkg::SRC_DISP: v = RW'(disp);
            dtn_pkg::SRC_VEL:  v = RW'(vel);
            dtn_pkg::SRC_ACC:  v = RW'(acc);
            dtn_pkg::SRC_PF:   v = RW'(pf);
            dtn_pkg::SRC_DIN:  v = RW'(din);
            dtn_pkg::SRC_VIN:  v = RW'(vin);
            dtn_pkg::SRC_FIN:  v = RW'(fin);
            default:           v = '0;
        endcase
        return v;
    endfunction

    assign spec_a = spec(i_ctl.uop.sa, i_cfg, r_disp, r_vel, r_accel, r_pf, r_din, r_vin, r_fin);
    assign spec_b = spec(i_ctl.uop.sb, i_cfg, r_disp, r_vel, r_accel, r_pf, r_din, r_vin, r_fin);

    // Operand fetch: registered scratch read or special source.
    always_ff @(posedge i_clk) begin
        if (i_ctl.fetch) begin
            r_opa <= i_ctl.uop.sa[4] ? spec_a : r_mem[i_ctl.uop.sa[3:0]];
            r_opb <= i_ctl.uop.sb[4] ? spec_b : r_mem[i_ctl.uop.sb[3:0]];
        end
    end

    // Shared multiplier with round-to-nearest and floor shift.
    assign prod    = $signed(r_opa[32:0]) * $signed(r_opb[32:0]);
    assign prod_sh = (prod + RND) >>> FRAC_BITS;
    assign mul_res = prod_sh[RW-1:0];

    // Saturation to 32 bits, used by the clip op and after a divide.
    assign sat_in    = i_ctl.div_wb ? RW'(div_q) : r_opa;
    assign sat_over  = (sat_in > MAX_R);
    assign sat_under = (sat_in < MIN_R);
    assign sat_out   = sat_over ? MAX_R : (sat_under ? MIN_R : sat_in);
    assign sat_sel   = (i_ctl.exec && (i_ctl.uop.op == dtn_pkg::OP_SAT)) || i_ctl.div_wb;

    // Result select.
    always_comb begin
        wb_val = r_opa;
        if (i_ctl.div_wb) begin
            wb_val = sat_out;
        end else begin
            case (i_ctl.uop.op)
                dtn_pkg::OP_ADD: wb_val = r_opa + r_opb;
                dtn_pkg::OP_SUB: wb_val = r_opa - r_opb;
                dtn_pkg::OP_MUL: wb_val = mul_res;
                dtn_pkg::OP_SAT: wb_val = sat_out;
                dtn_pkg::OP_LIN: wb_val = i_cfg.lin ? r_opb : r_opa;
                default:         wb_val = r_opa;
            endcase
        end
    end

    assign we = i_ctl.exec || i_ctl.div_wb;

    // Scratch memory write.
    always_ff @(posedge i_clk) begin
        if (we && !i_ctl.uop.dst[4]) begin
            r_mem[i_ctl.uop.dst[3:0]] <= wb_val;
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_din <= i_disp;
            r_vin <= i_vel;
            r_fin <= i_force;
        end
    end

    // Oscillator state and item flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp  <= '0;
            r_vel   <= '0;
            r_accel <= '0;
            r_pf    <= '0;
            r_clip  <= 1'b0;
            r_peak  <= 1'b0;
            r_first <= 1'b1;
        end else begin
            if (we && (i_ctl.uop.dst == dtn_pkg::SRC_DISP)) r_disp  <= wb_val[31:0];
            if (we && (i_ctl.uop.dst == dtn_pkg::SRC_VEL))  r_vel   <= wb_val[31:0];
            if (we && (i_ctl.uop.dst == dtn_pkg::SRC_ACC))  r_accel <= wb_val[31:0];
            if (we && (i_ctl.uop.dst == dtn_pkg::SRC_PF))   r_pf    <= wb_val[31:0];
            if (i_ctl.start) begin
                r_clip <= 1'b0;
                r_peak <= 1'b0;
            end else begin
                if ((sat_sel && (sat_over || sat_under)) || i_ctl.zero_hit) begin
                    r_clip <= 1'b1;
                end
                // Peak: old velocity non-negative, new velocity non-positive.
                if (i_ctl.peak_en) begin
                    r_peak <= !r_first && !r_opa[RW-1] && (r_opb[RW-1] || (r_opb == '0));
                end
            end
            if (i_ctl.finish) begin
                r_first <= i_ctl.load;
            end
        end
    end

    dtn_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (r_opa[31:0]),
        .i_den   (r_opb[31:0]),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_stat.a_zero   = (r_opa == '0);
    assign o_stat.div_done = div_done;
    assign o_disp  = r_disp;
    assign o_vel   = r_vel;
    assign o_accel = r_accel;
    assign o_peak  = r_peak;
    assign o_clip  = r_clip;

endmodule

// File: design/duffing_trapezoid_newton_step_unit.sv
// Each micro-op is fetched, then executed; a divide holds the sequencer in S_DIVW until the
// shared serial divider is done. A step word runs the Newton loop NEWTON_ITERS times (once
// in linear mode; a zero determinant skips the update), and a load word skips the step
// sequence. Throughput: one word at a time; the input is ready again in the same cycle that the
// result word appears, and a result word that waits holds the sequencer.
// Reset (synchronous, active low) clears the state, sets the first-step flag, loads defaults.
`include "duffing_trapezoid_newton_step_unit_assert.svh"

module duffing_trapezoid_newton_step_unit #(
    parameter int FRAC_BITS    = dtn_pkg::FRAC_BITS_DEF,
    parameter int NEWTON_ITERS = dtn_pkg::NEWTON_ITERS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    dtn_in_if.sink                    i_in,
    dtn_out_if.source                 o_res,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [dtn_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(NEWTON_ITERS + 1);

    dtn_pkg::t_state          r_state, n_state;
    logic [dtn_pkg::PC_W-1:0] r_pc, n_pc;
    logic [IW-1:0]            r_iter, n_iter;
    logic                     r_func, n_func;
    dtn_pkg::t_cfg            r_cfg;
    logic                     r_ovalid;
    logic signed [31:0]       r_odisp;
    logic signed [31:0]       r_ovel;
    logic signed [31:0]       r_oacc;
    logic                     r_opeak;
    logic                     r_oclip;

    dtn_pkg::t_uop     uop;
    dtn_pkg::t_dp_ctl  ctl;
    dtn_pkg::t_dp_stat stat;
    logic [IW-1:0]     iters;
    logic [IW-1:0]     iter_inc;
    logic signed [31:0] dp_disp;
    logic signed [31:0] dp_vel;
    logic signed [31:0] dp_acc;
    logic               dp_peak;
    logic               dp_clip;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h   <= dtn_pkg::H_RESET;
            r_cfg.xi  <= dtn_pkg::XI_RESET;
            r_cfg.lin <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dtn_pkg::CFG_STEP: r_cfg.h   <= i_cfg_data[dtn_pkg::H_W-1:0];
                dtn_pkg::CFG_DAMP: r_cfg.xi  <= i_cfg_data[dtn_pkg::XI_W-1:0];
                dtn_pkg::CFG_LIN:  r_cfg.lin <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign uop      = dtn_pkg::uop_at(r_pc);
    assign iters    = r_cfg.lin ? IW'(1) : IW'(NEWTON_ITERS);
    assign iter_inc = r_iter + IW'(1);

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtn_pkg::S_IDLE;
            r_pc    <= dtn_pkg::PC_STEP;
            r_iter  <= '0;
            r_func  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_iter  <= n_iter;
            r_func  <= n_func;
        end
    end

    // Next state and datapath controls.
    always_comb begin
        n_state       = r_state;
        n_pc          = r_pc;
        n_iter        = r_iter;
        n_func        = r_func;
        ctl           = '0;
        ctl.uop       = uop;
        ctl.load      = !r_func;
        i_in.ready    = 1'b0;
        case (r_state)
            dtn_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    ctl.start = 1'b1;
                    n_func    = i_in.func;
                    n_pc      = i_in.func ? dtn_pkg::PC_STEP : dtn_pkg::PC_LOAD;
                    n_iter    = '0;
                    n_state   = dtn_pkg::S_FETCH;
                end
            end
            dtn_pkg::S_FETCH: begin
                ctl.fetch = 1'b1;
                n_state   = dtn_pkg::S_EXEC;
            end
            dtn_pkg::S_EXEC: begin
                n_state = dtn_pkg::S_FETCH;
                n_pc    = r_pc + dtn_pkg::PC_W'(1);
                case (uop.op)
                    dtn_pkg::OP_ADD, dtn_pkg::OP_SUB, dtn_pkg::OP_MUL,
                    dtn_pkg::OP_SAT, dtn_pkg::OP_LIN: begin
                        ctl.exec = 1'b1;
                    end
                    dtn_pkg::OP_DIV: begin
                        ctl.div_start = 1'b1;
                        n_pc          = r_pc;
                        n_state       = dtn_pkg::S_DIVW;
                    end
                    dtn_pkg::OP_BRZ: begin
                        if (stat.a_zero) begin
                            ctl.zero_hit = 1'b1;
                            n_pc         = uop.tgt;
                        end
                    end
                    dtn_pkg::OP_JMP: begin
                        n_pc = uop.tgt;
                    end
                    dtn_pkg::OP_LOOP: begin
                        if (iter_inc < iters) begin
                            n_iter = iter_inc;
                            n_pc   = uop.tgt;
                        end
                    end
                    dtn_pkg::OP_PEAK: begin
                        ctl.peak_en = 1'b1;
                    end
                    dtn_pkg::OP_END: begin
                        n_pc    = r_pc;
                        n_state = dtn_pkg::S_PUSH;
                    end
                    default: ;
                endcase
            end
            dtn_pkg::S_DIVW: begin
                if (stat.div_done) begin
                    ctl.div_wb = 1'b1;
                    n_pc       = r_pc + dtn_pkg::PC_W'(1);
                    n_state    = dtn_pkg::S_FETCH;
                end
            end
            dtn_pkg::S_PUSH: begin
                if (!r_ovalid || o_res.ready) begin
                    ctl.finish = 1'b1;
                    n_state    = dtn_pkg::S_IDLE;
                end
            end
            default: n_state = dtn_pkg::S_IDLE;
        endcase
    end

    dtn_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cfg   (r_cfg),
        .i_disp  (i_in.disp_in),
        .i_vel   (i_in.vel_in),
        .i_force (i_in.force_in),
        .o_stat  (stat),
        .o_disp  (dp_disp),
        .o_vel   (dp_vel),
        .o_accel (dp_acc),
        .o_peak  (dp_peak),
        .o_clip  (dp_clip)
    );

    // Output register: holds a result word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctl.finish) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.finish) begin
            r_odisp <= dp_disp;
            r_ovel  <= dp_vel;
            r_oacc  <= dp_acc;
            r_opeak <= dp_peak;
            r_oclip <= dp_clip;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.disp_out  = r_odisp;
    assign o_res.vel_out   = r_ovel;
    assign o_res.accel_out = r_oacc;
    assign o_res.peak_seen = r_opeak;
    assign o_res.saturated = r_oclip;

    // An accepted word starts the program at its entry point.
    `DTN_ASSERT_NEXT(a_start_entry, i_clk, i_rst_n, i_in.valid && i_in.ready,
        r_state == dtn_pkg::S_FETCH && (r_pc == dtn_pkg::PC_STEP || r_pc == dtn_pkg::PC_LOAD))
    // The divider only finishes while the sequencer waits on it.
    `DTN_ASSERT_IMPL(a_div_wait, i_clk, i_rst_n, stat.div_done,
        r_state == dtn_pkg::S_DIVW)
    // The Newton iteration count stays within the configured bound.
    `DTN_ASSERT_IMPL(a_iter_bound, i_clk, i_rst_n, 1'b1,
        r_iter < IW'(NEWTON_ITERS))

endmodule

// File: tb/sv/dtn_step_checker.sv
module dtn_step_checker
    import dtn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dtn_in_if                in_ch,
    dtn_out_if               res_ch,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam longint ONE_Q = 64'sd65536;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] disp;
        logic signed [31:0] vel;
        logic signed [31:0] accel;
        logic               peak;
        logic               sat;
    } state_word_t;

    // Oscillator state and register copy.
    longint osc_disp, osc_vel, osc_accel, osc_force;
    bit     osc_first;
    longint reg_h, reg_xi;
    bit     reg_lin;
    bit     clipped;

    state_word_t expected_words[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_words.size();

    function automatic longint clip32(longint x);
        if (x > MAX32) begin
            clipped = 1'b1;
            return MAX32;
        end
        if (x < MIN32) begin
            clipped = 1'b1;
            return MIN32;
        end
        return x;
    endfunction

    // Rounded fixed-point product; the arithmetic shift floors.
    function automatic longint fxmul(longint a, longint b);
        longint p;
        p = a * b + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic longint accel_from(longint d, longint v, longint f);
        longint q;
        q = reg_lin ? ONE_Q : clip32(ONE_Q + fxmul(d, d));
        return clip32(f - fxmul(2 * reg_xi, v) - fxmul(d, q));
    endfunction

    // Advances the oscillator copy by one input word and returns the reported state.
    function automatic state_word_t advance_oscillator(bit func, longint din, longint vin,
                                                       longint fin);
        state_word_t w;
        longint hh, x2, d1, v1, u0, q0, g0, g1, m11;
        longint u, uu, q1, p, m10, j10, r0, r1, b0, b1, det, n0, n1;
        int     iters;
        bit     peak;
        peak    = 1'b0;
        clipped = 1'b0;
        if (!func) begin
            osc_disp  = din;
            osc_vel   = vin;
            osc_force = fin;
            osc_accel = accel_from(din, vin, fin);
            osc_first = 1'b1;
        end else begin
            hh    = reg_h >>> 1;
            x2    = 2 * reg_xi;
            iters = reg_lin ? 1 : 2;
            // Taylor predictor.
            d1 = clip32(osc_disp + fxmul(clip32(osc_vel + fxmul(osc_accel, hh)), reg_h));
            v1 = clip32(osc_vel + fxmul(osc_accel, reg_h));
            // Right-hand side of the trapezoid system.
            u0  = reg_lin ? 0 : osc_disp;
            q0  = clip32(ONE_Q + fxmul(u0, u0));
            g0  = clip32(osc_disp + fxmul(osc_vel, hh));
            g1  = clip32(osc_vel + fxmul(clip32(osc_force + fin - fxmul(q0, osc_disp)
                                                - fxmul(x2, osc_vel)), hh));
            m11 = clip32(ONE_Q + fxmul(reg_xi, reg_h));
            // Newton iterations solved by Cramer's rule.
            for (int it = 0; it < iters; it++) begin
                u   = reg_lin ? 0 : d1;
                uu  = fxmul(u, u);
                q1  = clip32(ONE_Q + uu);
                p   = clip32(ONE_Q + 3 * uu);
                m10 = clip32(fxmul(q1, hh));
                j10 = clip32(fxmul(p, hh));
                r0  = clip32(d1 - fxmul(hh, v1) - g0);
                r1  = clip32(fxmul(m10, d1) + fxmul(m11, v1) - g1);
                b0  = -r0;
                b1  = -r1;
                det = clip32(m11 + fxmul(hh, j10));
                if (det == 0) begin
                    clipped = 1'b1;
                end else begin
                    n0 = clip32(fxmul(clip32(b0), m11) + fxmul(hh, clip32(b1)));
                    n1 = clip32(b1 - fxmul(j10, clip32(b0)));
                    d1 = clip32(d1 + clip32((n0 * ONE_Q) / det));
                    v1 = clip32(v1 + clip32((n1 * ONE_Q) / det));
                end
            end
            if (!osc_first && osc_vel >= 0 && v1 <= 0) peak = 1'b1;
            osc_accel = accel_from(d1, v1, fin);
            osc_disp  = d1;
            osc_vel   = v1;
            osc_force = fin;
            osc_first = 1'b0;
        end
        w.disp  = osc_disp[31:0];
        w.vel   = osc_vel[31:0];
        w.accel = osc_accel[31:0];
        w.peak  = peak;
        w.sat   = clipped;
        return w;
    endfunction

    // Watch the register port and both channels.
    always @(posedge i_clk) begin
        state_word_t exp_w;
        bit          bad;
        if (!i_rst_n) begin
            osc_disp  = 0;
            osc_vel   = 0;
            osc_accel = 0;
            osc_force = 0;
            osc_first = 1'b1;
            reg_h     = longint'(H_RESET);
            reg_xi    = longint'(XI_RESET);
            reg_lin   = 1'b0;
            expected_words.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP: reg_h   = longint'(i_cfg_data[H_W-1:0]);
                    CFG_DAMP: reg_xi  = longint'(i_cfg_data[XI_W-1:0]);
                    CFG_LIN:  reg_lin = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: disp %h vel %h accel %h",
                                 res_ch.disp_out, res_ch.vel_out, res_ch.accel_out);
                end else begin
                    exp_w = expected_words.pop_front();
                    bad = (res_ch.disp_out !== exp_w.disp) || (res_ch.vel_out !== exp_w.vel)
                          || (res_ch.accel_out !== exp_w.accel)
                          || (res_ch.peak_seen !== exp_w.peak)
                          || (res_ch.saturated !== exp_w.sat);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected disp %h vel %h accel %h peak %b sat %b",
                                     exp_w.disp, exp_w.vel, exp_w.accel, exp_w.peak, exp_w.sat);
                            $display("          actual   disp %h vel %h accel %h peak %b sat %b",
                                     res_ch.disp_out, res_ch.vel_out, res_ch.accel_out,
                                     res_ch.peak_seen, res_ch.saturated);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(advance_oscillator(in_ch.func,
                    longint'(in_ch.disp_in), longint'(in_ch.vel_in),
                    longint'(in_ch.force_in)));
        end
    end

endmodule

// File: tb/sv/duffing_trapezoid_newton_step_unit_test.sv
module duffing_trapezoid_newton_step_unit_test;
    import dtn_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    int               fail_count;
    int               pending;
    int               load_count;
    int               step_count;
    int               cfg_count;
    bit               stim_done;

    dtn_in_if  in_ch ();
    dtn_out_if res_ch ();

    duffing_trapezoid_newton_step_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    dtn_step_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .res_ch       (res_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // Send one word after a random gap and wait for its handshake.
    task automatic send_word(bit func, logic [31:0] d, logic [31:0] v, logic [31:0] f);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= func;
        in_ch.disp_in  <= d;
        in_ch.vel_in   <= v;
        in_ch.force_in <= f;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (func) step_count++;
        else load_count++;
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_count++;
    endtask

    task automatic set_regs(logic [CFG_W-1:0] h, logic [CFG_W-1:0] xi, bit lin);
        write_reg(CFG_STEP, h);
        write_reg(CFG_DAMP, xi);
        write_reg(CFG_LIN, {{(CFG_W-1){1'b0}}, lin});
    endtask

    function automatic logic [31:0] near_value();
        return $urandom_range(0, 524288) - 262144;
    endfunction

    // Result side: a random stall before each word.
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // Stimulus and verdict.
    initial begin
        int steps;
        in_ch.valid    = 1'b0;
        in_ch.func     = 1'b0;
        in_ch.disp_in  = '0;
        in_ch.vel_in   = '0;
        in_ch.force_in = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_STEP;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        load_count     = 0;
        step_count     = 0;
        cfg_count      = 0;
        stim_done      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset register values.
        send_word(1'b1, 32'h0, 32'h0, 32'h0001_0000);
        send_word(1'b0, 32'h0, 32'h0, 32'h0);
        send_word(1'b1, 32'h0, 32'h0, 32'h0);
        send_word(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(1'b1, 32'h0, 32'h0, 32'h7fff_ffff);
        send_word(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
        send_word(1'b0, 32'h0001_0000, 32'h0, 32'h0);
        for (int i = 0; i < 6; i++) send_word(1'b1, 32'h0, 32'h0, 32'h0);
        drain_results();

        // Largest step and damping in linear mode, then smallest in cubic mode.
        set_regs(CFG_W'(65536), CFG_W'(655360), 1'b1);
        send_word(1'b0, 32'h0002_0000, 32'hfffe_0000, 32'h0);
        for (int i = 0; i < 4; i++) send_word(1'b1, 32'h0, 32'h0, near_value());
        send_word(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_word(1'b1, 32'h0, 32'h0, 32'h8000_0000);
        drain_results();
        set_regs(CFG_W'(1), CFG_W'(0), 1'b0);
        send_word(1'b0, 32'h0001_8000, 32'h0, 32'h0);
        for (int i = 0; i < 3; i++) send_word(1'b1, 32'h0, 32'h0, 32'h0);
        drain_results();

        // Random phases: loads each followed by a run of steps, mostly with moderate values.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: set_regs(CFG_W'($urandom_range(1, 65536)), CFG_W'($urandom_range(0, 655360)),
                            1'($urandom_range(0, 1)));
                1: set_regs(CFG_W'($urandom_range(300, 20000)), CFG_W'($urandom_range(0, 30000)),
                            1'b0);
                2: set_regs(CFG_W'(65536), CFG_W'($urandom_range(0, 655360)), 1'b1);
                default: set_regs(CFG_W'($urandom_range(1, 6554)), CFG_W'($urandom_range(0, 6554)),
                                  1'($urandom_range(0, 1)));
            endcase
            for (int n = 0; n < 140; n += steps + 1) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(1'b0, $urandom, $urandom, $urandom);
                else
                    send_word(1'b0, near_value(), near_value(), near_value());
                steps = $urandom_range(2, 20);
                for (int k = 0; k < steps; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
                    else
                        send_word(1'b1, $urandom, $urandom, near_value());
                end
            end
            drain_results();
        end
        stim_done = 1'b1;

        $display("covered %0d loads and %0d steps over %0d register writes,",
                 load_count, step_count, cfg_count);
        $display("with linear and cubic modes at extreme and random step and damping values");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #16000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: duffing_trapezoid_newton_step_unit.f
+incdir+design
design/dtn_pkg.sv
design/dtn_in_if.sv
design/dtn_out_if.sv
design/dtn_divider.sv
design/dtn_datapath.sv
design/duffing_trapezoid_newton_step_unit.sv
tb/sv/dtn_step_checker.sv
tb/sv/duffing_trapezoid_newton_step_unit_test.sv
